[hdl/bbr_pkg.sv]
package bbr_pkg;

	localparam int MAX_BANDS = 64;
	localparam int BAND_W    = $clog2(MAX_BANDS);
	localparam int NB_W      = BAND_W + 1;
	localparam int COL_W     = 32;
	localparam int FILL_W    = 16;
	localparam int CORE_W    = 8;
	localparam int BCNT_W    = 7;
	localparam int PAGE_W    = 14;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CORE_ID       = 2'd0,
		REG_BAND_COUNT    = 2'd1,
		REG_COLS_PER_BAND = 2'd2,
		REG_CAPACITY      = 2'd3
	} bbr_reg_t;

	typedef struct packed {
		logic             kind;
		logic [COL_W-1:0] bin_col;
	} bbr_in_t;

	typedef struct packed {
		logic              is_count;
		logic              accepted;
		logic [BAND_W-1:0] band;
		logic [FILL_W-1:0] slot;
		logic [PAGE_W-1:0] page;
		logic [FILL_W-1:0] count;
		logic              last;
	} bbr_out_t;

	typedef struct packed {
		logic [BAND_W-1:0] addr;
		logic              we;
		logic [FILL_W-1:0] wdata;
		logic              clear;
	} bbr_store_cmd_t;

endpackage

[hdl/band_bucket_router_top.sv]
// Route item: after acceptance come 32 divider steps, a band capture, a counter read and
// an update, then the result strobe; a new item is taken in the strobe cycle, so a route
// item is not taken before the last one's result.
// Drain item: one count report for each band in effect, each after a counter read;
// busy until the last report. Results cannot be stalled.
// Reset is asynchronous and active low; it clears settings, control state and band counts.
module band_bucket_router_top
	import bbr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  bbr_in_t              item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COL_W-1:0]     cfg_wdata,
	output logic                 result_valid,
	output bbr_out_t             result
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_DIV   = 5'b00010,
		S_RD    = 5'b00100,
		S_UPD   = 5'b01000,
		S_DOUT  = 5'b10000
	} bbr_state_t;

	bbr_state_t        state_q;
	logic [CORE_W-1:0] core_q;
	logic [BCNT_W-1:0] bcnt_q;
	logic [COL_W-1:0]  cols_q;
	logic [FILL_W-1:0] cap_q;
	logic [BAND_W-1:0] band_q;
	logic              strobe_q;
	bbr_out_t          result_q;

	logic              accept;
	logic [NB_W-1:0]   nb;
	logic [NB_W-1:0]   nb_m1;
	logic              div_start;
	logic              div_done;
	logic [COL_W-1:0]  quotient;
	logic              q_over;
	logic [BAND_W-1:0] band_clamped;
	logic [FILL_W-1:0] fill;
	logic              fits;
	logic [PAGE_W:0]   page_full;
	logic              drain_last;
	bbr_store_cmd_t    scmd;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		if (bcnt_q == '0) begin
			nb = NB_W'(1);
		end else if (bcnt_q > BCNT_W'(MAX_BANDS)) begin
			nb = NB_W'(MAX_BANDS);
		end else begin
			nb = NB_W'(bcnt_q);
		end
	end
	assign nb_m1 = nb - 1'b1;

	assign div_start = accept && !item.kind;

	bbr_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (item.bin_col),
		.divisor  (cols_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign q_over = (|quotient[COL_W-1:NB_W]) || (quotient[NB_W-1:0] > nb_m1);
	assign band_clamped = q_over ? nb_m1[BAND_W-1:0] : quotient[BAND_W-1:0];

	assign fits       = fill < cap_q;
	assign page_full  = (PAGE_W+1)'(core_q) * (PAGE_W+1)'(nb) + (PAGE_W+1)'(band_q);
	assign drain_last = ({1'b0, band_q} == nb_m1);

	always_comb begin
		scmd       = '0;
		scmd.addr  = band_q;
		scmd.wdata = fill + 1'b1;
		scmd.we    = (state_q == S_UPD) && fits;
		scmd.clear = (state_q == S_DOUT) && drain_last;
	end

	bbr_fill_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (scmd),
		.rdata  (fill)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_q <= '0;
			bcnt_q <= BCNT_W'(1);
			cols_q <= COL_W'(1);
			cap_q  <= '0;
		end else if (cfg_we) begin
			unique case (bbr_reg_t'(cfg_index))
				REG_CORE_ID:       core_q <= cfg_wdata[CORE_W-1:0];
				REG_BAND_COUNT:    bcnt_q <= cfg_wdata[BCNT_W-1:0];
				REG_COLS_PER_BAND: cols_q <= cfg_wdata;
				REG_CAPACITY:      cap_q  <= cfg_wdata[FILL_W-1:0];
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			band_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						band_q  <= '0;
						state_q <= item.kind ? S_RD : S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						band_q  <= band_clamped;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= (result_q.is_count) ? S_DOUT : S_UPD;
				end
				S_UPD: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_DOUT: begin
					strobe_q <= 1'b1;
					if (drain_last) begin
						state_q <= S_IDLE;
					end else begin
						band_q  <= band_q + 1'b1;
						state_q <= S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The kind of the item in flight is held in the is_count field until the
	// first result of that item is written.
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.is_count <= item.kind;
		end
		if (state_q == S_UPD) begin
			result_q.is_count <= 1'b0;
			result_q.accepted <= fits;
			result_q.band     <= band_q;
			result_q.slot     <= fits ? fill : '0;
			result_q.page     <= fits ? page_full[PAGE_W-1:0] : '0;
			result_q.count    <= '0;
			result_q.last     <= 1'b1;
		end else if (state_q == S_DOUT) begin
			result_q.is_count <= 1'b1;
			result_q.accepted <= 1'b0;
			result_q.band     <= band_q;
			result_q.slot     <= '0;
			result_q.page     <= '0;
			result_q.count    <= fill;
			result_q.last     <= drain_last;
		end
	end

	assign result_valid = strobe_q;
	assign result       = result_q;

endmodule

[hdl/bbr_divider.sv]
module bbr_divider
	import bbr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [COL_W-1:0] dividend,
	input  logic [COL_W-1:0] divisor,
	output logic             done,
	output logic [COL_W-1:0] quotient
);

	localparam int CNT_W = $clog2(COL_W);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [COL_W-1:0] rem_q;
	logic [COL_W-1:0] quo_q;
	logic [COL_W-1:0] dvs_q;
	logic [COL_W:0]   trial;
	logic [COL_W+1:0] diff;
	logic             ge;

	// One quotient bit per cycle; a zero divisor yields all ones.
	assign trial = {rem_q, quo_q[COL_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};
	assign ge    = ~diff[COL_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(COL_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[COL_W-1:0] : trial[COL_W-1:0];
			quo_q <= {quo_q[COL_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hdl/bbr_fill_store.sv]
module bbr_fill_store
	import bbr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  bbr_store_cmd_t    cmd,
	output logic [FILL_W-1:0] rdata
);

	logic [FILL_W-1:0]    mem [MAX_BANDS];
	logic [MAX_BANDS-1:0] valid_q;
	logic [FILL_W-1:0]    rd_q;
	logic                 rd_valid_q;

	// An entry not written since the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[cmd.addr];
			if (cmd.clear) begin
				valid_q <= '0;
			end else if (cmd.we) begin
				valid_q[cmd.addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[cmd.addr];
		if (cmd.we) begin
			mem[cmd.addr] <= cmd.wdata;
		end
	end

	assign rdata = rd_valid_q ? rd_q : '0;

endmodule

[hdl/bbr_checker.sv]
module bbr_checker
	import bbr_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     result_valid,
	input bbr_out_t result
);

	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
	else $error("accepted item did not make the block busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !result_valid)
	else $error("result transfer right after an item was accepted");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.is_count |-> result.last)
	else $error("routing result not marked as last");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.is_count || !result.accepted)
		|-> result.slot == '0 && result.page == '0)
	else $error("slot or page set on a count report or dropped record");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_count && !result.last |=> busy)
	else $error("drain ended before its last report");

endmodule

bind band_bucket_router_top bbr_checker u_bbr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

[test/band_bucket_router_top_test.sv]
module band_bucket_router_top_test
	import bbr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_ROUTE     = 1'b0;
	localparam logic KIND_DRAIN     = 1'b1;
	localparam int   WATCHDOG_LIMIT = 4000;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	bbr_in_t              item      = '0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_CORE_ID;
	logic [COL_W-1:0]     cfg_wdata = '0;
	logic                 result_valid;
	bbr_out_t             result;

	// Settings and bucket levels as the block should hold them.
	logic [CORE_W-1:0] core_sel   = '0;
	logic [BCNT_W-1:0] bands_set  = 7'd1;
	logic [COL_W-1:0]  cols_div   = 32'd1;
	logic [FILL_W-1:0] bucket_cap = '0;
	logic [FILL_W-1:0] bucket_level [MAX_BANDS] = '{default: '0};

	bbr_in_t  records_to_send [$];
	bbr_out_t routes_due [$];
	int       sent_count   = 0;
	int       taken_count  = 0;
	int       idle_left    = 0;
	bit       idling       = 1'b1;
	int       quiet_cycles = 0;
	int       mismatches   = 0;

	band_bucket_router_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void predict_routing(bbr_in_t rec);
		int          nb;
		int          b;
		int          page;
		logic [31:0] quot;
		bbr_out_t    r;
		nb = (bands_set == 0) ? 1 : (bands_set > MAX_BANDS) ? MAX_BANDS : int'(bands_set);
		if (rec.kind == KIND_DRAIN) begin
			for (int i = 0; i < nb; i++) begin
				r = '0;
				r.is_count = 1'b1;
				r.band = BAND_W'(i);
				r.count = bucket_level[i];
				r.last = (i == nb - 1);
				routes_due.push_back(r);
			end
			foreach (bucket_level[i]) bucket_level[i] = '0;
		end else begin
			quot = (cols_div == 0) ? '1 : rec.bin_col / cols_div;
			b = (quot >= nb) ? nb - 1 : int'(quot);
			r = '0;
			r.band = BAND_W'(b);
			r.last = 1'b1;
			if (bucket_level[b] < bucket_cap) begin
				page = int'(core_sel) * nb + b;
				r.accepted = 1'b1;
				r.slot = bucket_level[b];
				r.page = PAGE_W'(page);
				bucket_level[b] = bucket_level[b] + 1'b1;
			end
			routes_due.push_back(r);
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(negedge clk) begin
		if (arst_n && (!start || taken_count == sent_count)) begin
			if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
				item <= {1'($urandom_range(0, 1)), $urandom()};
			end else if (records_to_send.size() > 0) begin
				item <= records_to_send.pop_front();
				start <= 1'b1;
				sent_count++;
				if (idling && $urandom_range(0, 3) == 0) idle_left = $urandom_range(1, 5);
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		bbr_out_t want;
		if (arst_n) begin
			quiet_cycles++;
			if (start && !busy) begin
				predict_routing(item);
				taken_count++;
				quiet_cycles = 0;
			end
			if (result_valid) begin
				quiet_cycles = 0;
				if (routes_due.size() == 0) begin
					$error("result transfer with nothing expected");
					mismatches++;
				end else begin
					want = routes_due.pop_front();
					check_field("is_count", want.is_count, result.is_count);
					check_field("accepted", want.accepted, result.accepted);
					check_field("band", want.band, result.band);
					check_field("slot", want.slot, result.slot);
					check_field("page", want.page, result.page);
					check_field("count", want.count, result.count);
					check_field("last", want.last, result.last);
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send(logic kind, logic [COL_W-1:0] col);
		records_to_send.push_back('{kind: kind, bin_col: col});
	endtask

	task automatic wait_idle();
		while (records_to_send.size() != 0 || taken_count != sent_count
				|| routes_due.size() != 0 || busy)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(bbr_reg_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_CORE_ID:       core_sel = val[CORE_W-1:0];
			REG_BAND_COUNT:    bands_set = val[BCNT_W-1:0];
			REG_COLS_PER_BAND: cols_div = val;
			REG_CAPACITY:      bucket_cap = val[FILL_W-1:0];
		endcase
	endtask

	task automatic apply_settings(logic [31:0] core, logic [31:0] bands, logic [31:0] cols,
			logic [31:0] cap);
		wait_idle();
		write_reg(REG_CORE_ID, core);
		write_reg(REG_BAND_COUNT, bands);
		write_reg(REG_COLS_PER_BAND, cols);
		write_reg(REG_CAPACITY, cap);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int n_items);
		int          bands;
		int          nb;
		logic [31:0] cols;
		int          cap;
		longint      span;
		bands = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
		cols = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(1, 32);
		if ($urandom_range(0, 9) == 0) cols = '0;
		cap = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4);
		apply_settings($urandom(), {25'($urandom()), 7'(bands)}, cols,
			{16'($urandom()), 16'(cap)});
		nb = (bands == 0) ? 1 : (bands > MAX_BANDS) ? MAX_BANDS : bands;
		span = longint'(cols) * (nb + 1);
		if (span > 32'hFFFF_FFFF) span = 32'hFFFF_FFFF;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 9) == 0)
				send(KIND_DRAIN, $urandom());
			else if ($urandom_range(0, 7) == 0)
				send(KIND_ROUTE, $urandom());
			else
				send(KIND_ROUTE, $urandom_range(0, 32'(span)));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Settings after reset: one band, no room, so every record is dropped.
		send(KIND_ROUTE, 32'd0);
		send(KIND_ROUTE, 32'hFFFF_FFFF);
		send(KIND_DRAIN, 32'd0);

		// Largest core and band count: the page reaches its top value.
		apply_settings(32'd255, 32'd64, 32'd1, 32'd2);
		send(KIND_ROUTE, 32'd0);
		send(KIND_ROUTE, 32'd63);
		send(KIND_ROUTE, 32'd64);
		send(KIND_ROUTE, 32'hFFFF_FFFF);
		send(KIND_ROUTE, 32'd0);
		send(KIND_ROUTE, 32'd0);
		send(KIND_DRAIN, 32'hFFFF_FFFF);

		// A band count of zero means one band; a zero divisor sends all to the last band.
		apply_settings(32'd3, 32'd0, 32'd0, 32'd65535);
		send(KIND_ROUTE, 32'd7);
		send(KIND_ROUTE, 32'hFFFF_FFFF);
		send(KIND_DRAIN, 32'd0);

		// A band count above the maximum is limited to the maximum.
		apply_settings(32'd17, 32'd100, 32'd0, 32'd1);
		send(KIND_ROUTE, 32'd12);
		send(KIND_ROUTE, 32'd12);
		send(KIND_DRAIN, 32'd0);

		// Lowering the capacity below a filled bucket, then hiding and clearing a band.
		apply_settings(32'd9, 32'd4, 32'd16, 32'd3);
		send(KIND_ROUTE, 32'd0);
		send(KIND_ROUTE, 32'd1);
		send(KIND_ROUTE, 32'd2);
		send(KIND_ROUTE, 32'd100);
		apply_settings(32'd9, 32'd4, 32'd16, 32'd1);
		send(KIND_ROUTE, 32'd5);
		send(KIND_ROUTE, 32'd20);
		apply_settings(32'd9, 32'd2, 32'd16, 32'd1);
		send(KIND_DRAIN, 32'd0);
		apply_settings(32'd9, 32'd4, 32'd16, 32'd1);
		send(KIND_DRAIN, 32'd0);

		for (int p = 0; p < 5; p++) begin
			if (p == 4) begin
				wait_idle();
				idling = 1'b0;
			end
			random_phase(17);
		end

		wait_idle();
		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
